/* rtl/ntt_twiddle_generator_unit_defines.svh */
// Assertion macros shared by the twiddle generator RTL.
// Depends on nothing; included by modules that carry concurrent checks.
`ifndef NTT_TWIDDLE_GENERATOR_UNIT_DEFINES_SVH
`define NTT_TWIDDLE_GENERATOR_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define NTT_TW_ASSERT(lbl, ck, rn, prop, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);
`define NTT_TW_NEVER(lbl, ck, rn, cond, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) !(cond)) else $error(msg);
`else
`define NTT_TW_ASSERT(lbl, ck, rn, prop, msg)
`define NTT_TW_NEVER(lbl, ck, rn, cond, msg)
`endif
`endif

/* rtl/ntt_tw_pkg.sv */
// Shared types, constants and the modular double-and-add helper.
// Used by the controller, the datapath and the top level; depends on nothing.
package ntt_tw_pkg;

    localparam int DW = 16;
    localparam int SW = 34;
    localparam int CW = 4;
    localparam int LW = 5;
    localparam int IW = 2;

    localparam logic [IW-1:0] CFG_MODULUS  = 2'd0;
    localparam logic [IW-1:0] CFG_ROOT     = 2'd1;
    localparam logic [IW-1:0] CFG_LOG_SIZE = 2'd2;

    localparam logic [DW-1:0] MODULUS_RESET  = 16'd12289;
    localparam logic [DW-1:0] ROOT_RESET     = 16'd1;
    localparam logic [LW-1:0] LOG_SIZE_RESET = 5'd10;

    typedef enum logic [1:0] {
        OUT_POW,
        OUT_ZERO,
        OUT_NOINV
    } out_sel_t;

    typedef struct packed {
        logic           load;
        logic           red_init;
        logic           div_step;
        logic           take_base;
        logic           swap;
        logic           fix;
        logic           pow_init;
        logic           mul_start;
        logic           mul_step;
        logic           commit;
        logic           out_load;
        out_sel_t       out_sel;
        logic [CW-1:0]  bit_idx;
    } cmd_t;

    typedef struct packed {
        logic mod_small;
        logic dir;
        logic r1_zero;
        logic r0_one;
        logic e_zero;
        logic out_busy;
    } sts_t;

    // One step of interleaved modular multiplication: (2p + x) mod m, with p, x < m.
    function automatic logic [DW-1:0] mod_dbl_add(input logic [DW-1:0] p,
                                                  input logic [DW-1:0] x,
                                                  input logic [DW-1:0] m);
        logic [DW+1:0] t;
        logic [DW+1:0] m1;
        logic [DW+1:0] m2;
        m1 = {2'b00, m};
        m2 = {1'b0, m, 1'b0};
        t  = {1'b0, p, 1'b0} + {2'b00, x};
        if (t >= m2)
            t = t - m2;
        else if (t >= m1)
            t = t - m1;
        return t[DW-1:0];
    endfunction

endpackage

/* rtl/ntt_twiddle_generator_unit.sv */
// Top level of the bit-reversed NTT twiddle factor generator.
// Depends on ntt_tw_pkg, ntt_tw_ctrl and ntt_tw_dp.
//
// Usage: configuration is written through cfg_we/cfg_index/cfg_wdata while the block
// is idle (index 0 modulus, 1 root, 2 log size). A request on the in channel carries
// a table position and a direction; the block answers with one request on the out
// channel holding the twiddle factor and the no-inverse flag.
// Latency is data dependent. A modulus below two is answered with a zero twiddle
// and no arithmetic. Otherwise the root is first reduced by a shift-subtract sweep.
// In the inverse direction each extended Euclid step is then a shift-subtract
// sweep and a swap, and a 16-bit modulus needs at most about 25 steps.
// Exponentiation then works through the reversed exponent bit by bit up to its
// highest set bit; the product and the square share the same 16-step
// double-and-add sweep. One request is in work at a time; in_ready is high only
// while idle.
// The result sits in an output register, so a new request is accepted while the
// previous result still waits; if the receiver stalls, the finished result of the
// next request waits in the sequencer until the register frees up.
// Reset restores modulus 12289, root 1 and log size 10 and empties the output register.
module ntt_twiddle_generator_unit #(
    parameter int MAX_LOG_SIZE = 16,
    parameter int MOD_BITS     = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [ntt_tw_pkg::IW-1:0]     cfg_index,
    input  logic [ntt_tw_pkg::DW-1:0]     cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [ntt_tw_pkg::DW-1:0]     index,
    input  logic                          direction,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ntt_tw_pkg::DW-1:0]     twiddle,
    output logic                          no_inverse
);

    ntt_tw_pkg::cmd_t cmd;
    ntt_tw_pkg::sts_t sts;

    // The sequencer owns all timing; besides configuration writes and out_ready, the datapath only reacts to commands.
    ntt_tw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // The datapath holds the configuration, the Euclid remainders and
    // coefficients, the two multiply lanes and the output register.
    ntt_tw_dp #(
        .MAX_LOG_SIZE (MAX_LOG_SIZE),
        .MOD_BITS     (MOD_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .index      (index),
        .direction  (direction),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .twiddle    (twiddle),
        .no_inverse (no_inverse),
        .cmd        (cmd),
        .sts        (sts)
    );

endmodule

/* rtl/ntt_tw_dp.sv */
// Datapath: configuration registers, Euclid and reduction registers, power lanes.
// Depends on ntt_tw_pkg; driven by ntt_tw_ctrl through cmd_t and sts_t.
module ntt_tw_dp #(
    parameter int MAX_LOG_SIZE = 16,
    parameter int MOD_BITS     = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [ntt_tw_pkg::IW-1:0]     cfg_index,
    input  logic [ntt_tw_pkg::DW-1:0]     cfg_wdata,
    input  logic [ntt_tw_pkg::DW-1:0]     index,
    input  logic                          direction,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [ntt_tw_pkg::DW-1:0]     twiddle,
    output logic                          no_inverse,
    input  ntt_tw_pkg::cmd_t              cmd,
    output ntt_tw_pkg::sts_t              sts
);

    localparam int DW = ntt_tw_pkg::DW;
    localparam int SW = ntt_tw_pkg::SW;
    localparam int LW = ntt_tw_pkg::LW;
    localparam logic [DW-1:0] MOD_MASK = DW'((64'd1 << MOD_BITS) - 64'd1);

    logic [DW-1:0]        mod_reg;
    logic [DW-1:0]        root_reg;
    logic [LW-1:0]        lsz_reg;
    logic                 out_valid_reg;
    logic [DW-1:0]        tw_reg;
    logic                 noinv_reg;
    logic [DW-1:0]        e_reg;
    logic                 dir_reg;
    logic [DW-1:0]        r0_reg;
    logic [DW-1:0]        r1_reg;
    logic signed [SW-1:0] s0_reg;
    logic signed [SW-1:0] s1_reg;
    logic [DW-1:0]        base_reg;
    logic [DW-1:0]        acc_reg;
    logic [DW-1:0]        pa_reg;
    logic [DW-1:0]        pb_reg;

    logic [LW-1:0]        bits_eff;
    logic [DW-1:0]        e_rev;
    logic [2*DW-1:0]      r1_sh;
    logic                 sub_ok;
    logic signed [SW-1:0] s1_sh;
    logic signed [SW-1:0] m_ext;
    logic signed [SW-1:0] s_fix;
    logic                 mbit;

    // Bit reversal of the table position over the effective log size.
    always_comb
    begin
        logic [ntt_tw_pkg::CW-1:0] pos;
        bits_eff = (lsz_reg > LW'(MAX_LOG_SIZE)) ? LW'(MAX_LOG_SIZE) : lsz_reg;
        e_rev    = '0;
        for (int j = 0; j < DW; j++)
        begin
            pos = ntt_tw_pkg::CW'(bits_eff - 5'd1 - LW'(j));
            if (LW'(j) < bits_eff)
                e_rev[j] = index[pos];
        end
    end

    assign r1_sh  = {{DW{1'b0}}, r1_reg} << cmd.bit_idx;
    assign sub_ok = (r1_sh <= {{DW{1'b0}}, r0_reg});
    assign s1_sh  = s1_reg <<< cmd.bit_idx;
    assign m_ext  = signed'({{(SW-DW){1'b0}}, mod_reg});
    assign mbit   = base_reg[cmd.bit_idx];

    always_comb
    begin
        if (s0_reg < 0)
            s_fix = s0_reg + m_ext;
        else if (s0_reg >= m_ext)
            s_fix = s0_reg - m_ext;
        else
            s_fix = s0_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mod_reg       <= ntt_tw_pkg::MODULUS_RESET;
            root_reg      <= ntt_tw_pkg::ROOT_RESET;
            lsz_reg       <= ntt_tw_pkg::LOG_SIZE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    ntt_tw_pkg::CFG_MODULUS:  mod_reg  <= cfg_wdata & MOD_MASK;
                    ntt_tw_pkg::CFG_ROOT:     root_reg <= cfg_wdata;
                    ntt_tw_pkg::CFG_LOG_SIZE: lsz_reg  <= cfg_wdata[LW-1:0];
                    default:                  ;
                endcase
            end
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            e_reg   <= e_rev;
            dir_reg <= direction;
        end
        if (cmd.red_init)
        begin
            r0_reg <= root_reg;
            r1_reg <= mod_reg;
            s0_reg <= '0;
            s1_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            if (sub_ok)
            begin
                r0_reg <= r0_reg - r1_sh[DW-1:0];
                s0_reg <= s0_reg - s1_sh;
            end
        end
        else if (cmd.take_base)
        begin
            base_reg <= r0_reg;
            r1_reg   <= mod_reg;
            s0_reg   <= SW'(1);
            s1_reg   <= '0;
        end
        else if (cmd.swap)
        begin
            r0_reg <= r1_reg;
            r1_reg <= r0_reg;
            s0_reg <= s1_reg;
            s1_reg <= s0_reg;
        end
        if (cmd.fix)
            base_reg <= s_fix[DW-1:0];
        if (cmd.pow_init)
            acc_reg <= DW'(1);
        if (cmd.mul_start)
        begin
            pa_reg <= '0;
            pb_reg <= '0;
        end
        else if (cmd.mul_step)
        begin
            pa_reg <= ntt_tw_pkg::mod_dbl_add(pa_reg, mbit ? acc_reg : '0, mod_reg);
            pb_reg <= ntt_tw_pkg::mod_dbl_add(pb_reg, mbit ? base_reg : '0, mod_reg);
        end
        if (cmd.commit)
        begin
            if (e_reg[0])
                acc_reg <= pa_reg;
            base_reg <= pb_reg;
            e_reg    <= e_reg >> 1;
        end
        if (cmd.out_load)
        begin
            unique case (cmd.out_sel)
                ntt_tw_pkg::OUT_POW:
                begin
                    tw_reg    <= acc_reg;
                    noinv_reg <= 1'b0;
                end
                ntt_tw_pkg::OUT_NOINV:
                begin
                    tw_reg    <= '0;
                    noinv_reg <= 1'b1;
                end
                default:
                begin
                    tw_reg    <= '0;
                    noinv_reg <= 1'b0;
                end
            endcase
        end
    end

    assign sts.mod_small = (mod_reg < DW'(2));
    assign sts.dir       = dir_reg;
    assign sts.r1_zero   = (r1_reg == '0);
    assign sts.r0_one    = (r0_reg == DW'(1));
    assign sts.e_zero    = (e_reg == '0);
    assign sts.out_busy  = out_valid_reg && !out_ready;

    assign out_valid  = out_valid_reg;
    assign twiddle    = tw_reg;
    assign no_inverse = noinv_reg;

endmodule

/* rtl/ntt_tw_ctrl.sv */
// Sequencer for reduction, extended Euclid and square-and-multiply.
// Depends on ntt_tw_pkg and the assertion macro header.
`include "ntt_twiddle_generator_unit_defines.svh"
module ntt_tw_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ntt_tw_pkg::sts_t  sts,
    output ntt_tw_pkg::cmd_t  cmd
);

    localparam int CW = ntt_tw_pkg::CW;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RED,
        ST_TAKE,
        ST_ECHK,
        ST_EDIV,
        ST_ESWAP,
        ST_FIX,
        ST_PINIT,
        ST_PCHK,
        ST_PMUL,
        ST_PCOMMIT,
        ST_FIN
    } state_t;

    state_t               state_reg, state_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    ntt_tw_pkg::out_sel_t sel_reg, sel_next;

    logic                 in_fire;
    logic                 load_clash;
    logic                 div_busy;
    logic                 mul_last;
    logic [CW-1:0]        cnt_dec;

    assign cnt_dec = cnt_reg - 1'b1;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        sel_next   = sel_reg;
        cmd        = '0;
        cmd.out_sel = sel_reg;
        cmd.bit_idx = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (sts.mod_small)
                    begin
                        sel_next   = ntt_tw_pkg::OUT_ZERO;
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        cmd.red_init = 1'b1;
                        cnt_next     = '1;
                        state_next   = ST_RED;
                    end
                end
            end
            ST_RED:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_dec;
                if (cnt_reg == '0)
                    state_next = ST_TAKE;
            end
            ST_TAKE:
            begin
                cmd.take_base = 1'b1;
                state_next    = sts.dir ? ST_ECHK : ST_PINIT;
            end
            ST_ECHK:
            begin
                if (sts.r1_zero)
                begin
                    if (sts.r0_one)
                        state_next = ST_FIX;
                    else
                    begin
                        sel_next   = ntt_tw_pkg::OUT_NOINV;
                        state_next = ST_FIN;
                    end
                end
                else
                begin
                    cnt_next   = '1;
                    state_next = ST_EDIV;
                end
            end
            ST_EDIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_dec;
                if (cnt_reg == '0)
                    state_next = ST_ESWAP;
            end
            ST_ESWAP:
            begin
                cmd.swap   = 1'b1;
                state_next = ST_ECHK;
            end
            ST_FIX:
            begin
                cmd.fix    = 1'b1;
                state_next = ST_PINIT;
            end
            ST_PINIT:
            begin
                cmd.pow_init = 1'b1;
                state_next   = ST_PCHK;
            end
            ST_PCHK:
            begin
                if (sts.e_zero)
                begin
                    sel_next   = ntt_tw_pkg::OUT_POW;
                    state_next = ST_FIN;
                end
                else
                begin
                    cmd.mul_start = 1'b1;
                    cnt_next      = '1;
                    state_next    = ST_PMUL;
                end
            end
            ST_PMUL:
            begin
                cmd.mul_step = 1'b1;
                cnt_next     = cnt_dec;
                if (cnt_reg == '0)
                    state_next = ST_PCOMMIT;
            end
            ST_PCOMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = ST_PCHK;
            end
            ST_FIN:
            begin
                if (!sts.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            sel_reg   <= ntt_tw_pkg::OUT_ZERO;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            sel_reg   <= sel_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    assign in_fire    = in_valid && in_ready;
    assign load_clash = cmd.out_load && sts.out_busy;
    assign div_busy   = (state_reg == ST_EDIV) && (cnt_reg != '0);
    assign mul_last   = (state_reg == ST_PMUL) && (cnt_reg == '0);

    `NTT_TW_NEVER(a_load_when_busy, clk, rst_n, load_clash, "result overwritten")
    `NTT_TW_ASSERT(a_accept_start, clk, rst_n, in_fire |=> !in_ready, "request not started")
    `NTT_TW_ASSERT(a_div_cnt, clk, rst_n, div_busy |=> cnt_reg == $past(cnt_dec), "sweep broken")
    `NTT_TW_ASSERT(a_mul_to_commit, clk, rst_n, mul_last |=> cmd.commit, "multiply not committed")

endmodule
